// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the sigma clip filter.
// Expects the including module to have signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SFC_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sigma clip filter: assertion failed");

// Next-cycle implication.
`define SFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sigma clip filter: assertion failed");

`endif

// ===== rtl/core/sfc_pkg.sv =====
// Shared types and constants of the sigma clip filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfc_pkg;

   localparam int LIST_DEPTH = 64;
   localparam int VALUE_BITS = 10;

   localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;
   localparam longint unsigned SUM_MAX   = LIST_DEPTH * VALUE_MAX;
   localparam longint unsigned SQ_MAX    = LIST_DEPTH * VALUE_MAX * VALUE_MAX;

   localparam int CNT_BITS  = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_BITS = $clog2(LIST_DEPTH);
   localparam int SUM_BITS  = $clog2(SUM_MAX + 1);
   localparam int SQ_BITS   = $clog2(SQ_MAX + 1);
   localparam int X2_BITS   = 2 * VALUE_BITS;
   localparam int NX_BITS   = CNT_BITS + VALUE_BITS;
   localparam int NQ_BITS   = CNT_BITS + SQ_BITS;
   localparam int SS_BITS   = 2 * SUM_BITS;
   localparam int VAR_BITS  = NQ_BITS;
   localparam int DSQ_BITS  = 2 * SUM_BITS;
   localparam int LHS_BITS  = DSQ_BITS + 8;

   localparam int SIGMA_BITS  = 8;
   localparam int SIG2_BITS   = 2 * SIGMA_BITS;
   localparam int RHS_BITS    = SIG2_BITS + VAR_BITS;
   localparam int CMP_BITS    = (LHS_BITS > RHS_BITS) ? LHS_BITS : RHS_BITS;
   localparam logic [SIGMA_BITS-1:0] SIGMA_RESET = 8'd32;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_SIGMA = 1'b0;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MUL,
      ST_SUB,
      ST_RHS,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_en;
      logic prep_mul;
      logic prep_sub;
      logic prep_rhs;
      logic scan_issue;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_accept;
      logic issue_done;
      logic pipe_busy;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/sigma_clip_filter.sv =====
// Sigma clip filter. Requests are taken one per cycle while a list loads; the
// request marked last starts filtering, and the block takes no request until
// the run has been handed to the result register. After the last request, the
// states ST_MUL, ST_SUB and ST_RHS compute the threshold s^2*(n*Q-S^2), then
// the n stored values stream through a read/multiply/square/compare pipeline,
// one per cycle unless the result register stalls it, and the finish state
// issues the final result. Kept values leave in input order; the last carries
// end_of_run, and a run with no kept value gives a single none_kept result.
// Values past the buffer depth are dropped and flagged. sigma_q4 sits at byte
// address 0 of the APB port.
`default_nettype none
`include "assert_macros.svh"

module sigma_clip_filter import sfc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [VALUE_BITS-1:0]    req_sample_value,
   input  logic                     req_is_last,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [VALUE_BITS-1:0]    rsp_kept_value,
   output logic                     rsp_none_kept,
   output logic                     rsp_overflowed,
   output logic                     rsp_end_of_run,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   ctrl_cmd_type          cmd;
   dp_status_type         status;
   logic [SIGMA_BITS-1:0] sigma_q4;

   sfc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .sigma_q4 (sigma_q4)
   );

   sfc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   sfc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .sigma_q4         (sigma_q4),
      .req_valid        (req_valid),
      .req_sample_value (req_sample_value),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kept_value   (rsp_kept_value),
      .rsp_none_kept    (rsp_none_kept),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_end_of_run   (rsp_end_of_run)
   );

   assign req_ready = cmd.load_en;

   `SFC_ASSERT_IMPLIES(a_none_ends_run, rsp_valid && rsp_none_kept, rsp_end_of_run)
   `SFC_ASSERT_NEXT(a_last_stops_load, req_valid && req_ready && req_is_last, !req_ready)
   `SFC_ASSERT_NEXT(a_finish_emits_end, cmd.finish && status.out_free, rsp_valid && rsp_end_of_run)

endmodule

`default_nettype wire

// ===== rtl/core/sfc_csr.sv =====
// Configuration register file: holds the clipping factor sigma_q4.
// Depends on sfc_pkg.
`default_nettype none

module sfc_csr import sfc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [SIGMA_BITS-1:0]    sigma_q4
);

   logic [SIGMA_BITS-1:0] sigma_ff;
   logic [SIGMA_BITS-1:0] sigma_in;
   logic                  sel_sigma;

   // word index is the address bit above the byte offset
   assign sel_sigma = (paddr[2] == CSR_IDX_SIGMA);

   always_comb begin
      sigma_in = sigma_ff;
      if (psel && penable && pwrite && sel_sigma) begin
         sigma_in = pwdata[SIGMA_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIGMA_RESET;
      end else begin
         sigma_ff <= sigma_in;
      end
   end

   assign prdata   = sel_sigma ? CSR_DATA_BITS'(sigma_ff) : '0;
   assign pready   = 1'b1;
   assign sigma_q4 = sigma_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sfc_ctrl.sv =====
// Controller of the sigma clip filter: sequences load, set-up, scan and finish.
// Depends on sfc_pkg; drives sfc_datapath through the command struct.
`default_nettype none

module sfc_ctrl import sfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (status.last_accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUB;
         ST_SUB:  state_in = ST_RHS;
         ST_RHS:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.issue_done && !status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_LOAD:   cmd.load_en    = 1'b1;
         ST_MUL:    cmd.prep_mul   = 1'b1;
         ST_SUB:    cmd.prep_sub   = 1'b1;
         ST_RHS:    cmd.prep_rhs   = 1'b1;
         ST_SCAN:   cmd.scan_issue = 1'b1;
         ST_FINISH: cmd.finish     = 1'b1;
         default:   cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/sfc_datapath.sv =====
// Datapath of the sigma clip filter: value buffer, running sums, threshold
// set-up, scan pipeline and result registers. Depends on sfc_pkg.
`default_nettype none

module sfc_datapath import sfc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   input  logic [SIGMA_BITS-1:0] sigma_q4,
   input  logic                  req_valid,
   input  logic [VALUE_BITS-1:0] req_sample_value,
   input  logic                  req_is_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_kept_value,
   output logic                  rsp_none_kept,
   output logic                  rsp_overflowed,
   output logic                  rsp_end_of_run
);

   logic [VALUE_BITS-1:0] value_mem [LIST_DEPTH];

   // list state
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [SQ_BITS-1:0]   sq_ff, sq_in;
   logic                 ovf_ff, ovf_in;

   // threshold set-up
   logic [NQ_BITS-1:0]   nq_ff, nq_in;
   logic [SS_BITS-1:0]   ss_ff, ss_in;
   logic [SIG2_BITS-1:0] sig2_ff, sig2_in;
   logic [VAR_BITS-1:0]  var_ff, var_in;
   logic [RHS_BITS-1:0]  rhs_ff, rhs_in;

   // scan pipeline
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic                  v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [VALUE_BITS-1:0] rd_value_ff;
   logic [VALUE_BITS-1:0] val2_ff, val2_in, val3_ff, val3_in;
   logic [SUM_BITS-1:0]   d2_ff, d2_in;
   logic [DSQ_BITS-1:0]   dsq3_ff, dsq3_in;

   // pending kept value and output register
   logic                  pend_valid_ff, pend_valid_in;
   logic [VALUE_BITS-1:0] pend_value_ff, pend_value_in;
   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0] out_value_ff, out_value_in;
   logic                  out_none_ff, out_none_in;
   logic                  out_ovf_ff, out_ovf_in;
   logic                  out_eor_ff, out_eor_in;

   logic                accept, room, store, issue, adv, pass, out_free, final_fire;
   logic [X2_BITS-1:0]  x_sq;
   logic [NX_BITS-1:0]  nx;
   logic [NX_BITS-1:0]  sum_ext;
   logic [LHS_BITS-1:0] lhs;

   assign accept     = req_valid && cmd.load_en;
   assign room       = (count_ff < CNT_BITS'(LIST_DEPTH));
   assign store      = accept && room;
   assign out_free   = !out_valid_ff || rsp_ready;
   assign lhs        = {dsq3_ff, 8'd0};
   assign pass       = v3_ff && (CMP_BITS'(lhs) < CMP_BITS'(rhs_ff));
   // a second pass while the pending slot is full needs the output register
   assign adv        = !(pass && pend_valid_ff && !out_free);
   assign issue      = cmd.scan_issue && (idx_ff != count_ff) && adv;
   assign final_fire = cmd.finish && out_free;

   assign x_sq    = X2_BITS'(req_sample_value) * X2_BITS'(req_sample_value);
   assign nx      = NX_BITS'(count_ff) * NX_BITS'(rd_value_ff);
   assign sum_ext = NX_BITS'(sum_ff);

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      if (store) begin
         count_in = count_ff + CNT_BITS'(1);
         sum_in   = sum_ff + SUM_BITS'(req_sample_value);
         sq_in    = sq_ff + SQ_BITS'(x_sq);
      end else if (accept) begin
         ovf_in = 1'b1;
      end
      if (issue) begin
         idx_in = idx_ff + CNT_BITS'(1);
      end
      if (final_fire) begin
         count_in = '0;
         sum_in   = '0;
         sq_in    = '0;
         ovf_in   = 1'b0;
         idx_in   = '0;
      end
   end

   always_comb begin
      nq_in   = nq_ff;
      ss_in   = ss_ff;
      sig2_in = sig2_ff;
      var_in  = var_ff;
      rhs_in  = rhs_ff;
      if (cmd.prep_mul) begin
         nq_in   = NQ_BITS'(count_ff) * NQ_BITS'(sq_ff);
         ss_in   = SS_BITS'(sum_ff) * SS_BITS'(sum_ff);
         sig2_in = SIG2_BITS'(sigma_q4) * SIG2_BITS'(sigma_q4);
      end
      // n*Q >= S^2, so the difference fits the width of n*Q
      if (cmd.prep_sub) begin
         var_in = nq_ff - VAR_BITS'(ss_ff);
      end
      if (cmd.prep_rhs) begin
         rhs_in = RHS_BITS'(sig2_ff) * RHS_BITS'(var_ff);
      end
   end

   always_comb begin
      v1_in   = adv ? issue : v1_ff;
      v2_in   = adv ? v1_ff : v2_ff;
      v3_in   = adv ? v2_ff : v3_ff;
      val2_in = adv ? rd_value_ff : val2_ff;
      val3_in = adv ? val2_ff : val3_ff;
      d2_in   = d2_ff;
      dsq3_in = adv ? DSQ_BITS'(d2_ff) * DSQ_BITS'(d2_ff) : dsq3_ff;
      if (adv) begin
         d2_in = (nx >= sum_ext) ? SUM_BITS'(nx - sum_ext) : SUM_BITS'(sum_ext - nx);
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_value_in  = out_value_ff;
      out_none_in   = out_none_ff;
      out_ovf_in    = out_ovf_ff;
      out_eor_in    = out_eor_ff;
      if (adv && pass) begin
         pend_valid_in = 1'b1;
         pend_value_in = val3_ff;
         // earlier pass is now known not to be the last one
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_value_in = pend_value_ff;
            out_none_in  = 1'b0;
            out_ovf_in   = ovf_ff;
            out_eor_in   = 1'b0;
         end
      end
      if (final_fire) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
         out_value_in  = pend_valid_ff ? pend_value_ff : '0;
         out_none_in   = !pend_valid_ff;
         out_ovf_in    = ovf_ff;
         out_eor_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         value_mem[count_ff[ADDR_BITS-1:0]] <= req_sample_value;
      end
      if (issue) begin
         rd_value_ff <= value_mem[idx_ff[ADDR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sum_ff        <= '0;
         sq_ff         <= '0;
         ovf_ff        <= 1'b0;
         idx_ff        <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         sq_ff         <= sq_in;
         ovf_ff        <= ovf_in;
         idx_ff        <= idx_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nq_ff         <= nq_in;
      ss_ff         <= ss_in;
      sig2_ff       <= sig2_in;
      var_ff        <= var_in;
      rhs_ff        <= rhs_in;
      val2_ff       <= val2_in;
      val3_ff       <= val3_in;
      d2_ff         <= d2_in;
      dsq3_ff       <= dsq3_in;
      pend_value_ff <= pend_value_in;
      out_value_ff  <= out_value_in;
      out_none_ff   <= out_none_in;
      out_ovf_ff    <= out_ovf_in;
      out_eor_ff    <= out_eor_in;
   end

   always_comb begin
      status.last_accept = accept && req_is_last;
      status.issue_done  = (idx_ff == count_ff);
      status.pipe_busy   = v1_ff || v2_ff || v3_ff;
      status.out_free    = out_free;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kept_value = out_value_ff;
   assign rsp_none_kept  = out_none_ff;
   assign rsp_overflowed = out_ovf_ff;
   assign rsp_end_of_run = out_eor_ff;

endmodule

`default_nettype wire
